[src/dqu_pkg.sv]
// Shared types, constants and index helpers for the double-ended queue unit.
// No dependencies; dqu_ctrl and double_ended_queue_unit import this package.
`default_nettype none

package dqu_pkg;

    // Store geometry
    localparam int DEPTH  = 128;
    localparam int IDX_W  = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int DATA_W = 32;

    // Word returned when nothing is read
    localparam logic [DATA_W-1:0] EMPTY_WORD = {DATA_W{1'b1}};

    // Request operation codes
    typedef enum logic [2:0] {
        OP_PUSH_FRONT = 3'd0,
        OP_PUSH_BACK  = 3'd1,
        OP_POP_FRONT  = 3'd2,
        OP_POP_BACK   = 3'd3,
        OP_PEEK_FRONT = 3'd4,
        OP_PEEK_BACK  = 3'd5
    } t_op;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_OVERFLOW = 2'd1,
        ST_EMPTY    = 2'd2
    } t_status;

    // Single-port store access issued by the control logic
    typedef struct packed {
        logic              we;
        logic              re;
        logic [IDX_W-1:0]  addr;
        logic [DATA_W-1:0] wdata;
    } t_mem_req;

    // Result fields that do not come from the store
    typedef struct packed {
        logic             rd_used;
        t_status          status;
        logic [CNT_W-1:0] count;
        logic             empty;
    } t_res_meta;

    // Advance an index with wrap at DEPTH
    function automatic logic [IDX_W-1:0] idx_inc(input logic [IDX_W-1:0] i);
        return (i == IDX_W'(DEPTH - 1)) ? '0 : i + IDX_W'(1);
    endfunction

    // Step an index back with wrap at DEPTH
    function automatic logic [IDX_W-1:0] idx_dec(input logic [IDX_W-1:0] i);
        return (i == '0) ? IDX_W'(DEPTH - 1) : i - IDX_W'(1);
    endfunction

    // Low eight bits of a count, zero extended when the count is narrower
    function automatic logic [7:0] count8(input logic [CNT_W-1:0] c);
        logic [CNT_W+7:0] ext;
        ext = {8'b0, c};
        return ext[7:0];
    endfunction

endpackage

`default_nettype wire

[src/double_ended_queue_unit.sv]
// Double-ended queue unit: one request in, one result out.
// The result is registered and is valid in the cycle after the request is accepted.
// Throughput: one request per cycle while results are taken; the single store port serves one access each.
// Reset clears head, tail, count and the result valid; the store is not cleared.
// Depends on dqu_pkg, dqu_ctrl and dqu_ram.
`default_nettype none

module double_ended_queue_unit (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [31:0] i_s_tdata,   // [31:0] push_value
    input  wire logic [2:0]  i_s_tuser,   // [2:0] operation
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic      [47:0] o_m_tdata,   // [31:0] read_value, [39:32] entry_count,
                                          // [40] is_empty, [47:41] zero
    output logic      [1:0]  o_m_tuser    // [1:0] status
);

    import dqu_pkg::*;

    logic              accept;
    t_mem_req          mem_req;
    t_res_meta         meta;
    logic [DATA_W-1:0] rdata;
    logic              r_valid;
    t_res_meta         r_meta;
    logic [DATA_W-1:0] read_value;

    // Take a request when the result slot is free or drains this cycle
    assign o_s_tready = !r_valid || i_m_tready;
    assign accept     = i_s_tvalid && o_s_tready;

    dqu_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_op         (i_s_tuser),
        .i_push_value (i_s_tdata),
        .o_mem_req    (mem_req),
        .o_meta       (meta)
    );

    dqu_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_req.we),
        .i_re    (mem_req.re),
        .i_addr  (mem_req.addr),
        .i_wdata (mem_req.wdata),
        .o_rdata (rdata)
    );

    // Result valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_valid <= 1'b0;
        end
    end

    // Hold result fields alongside the RAM read data
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_meta <= meta;
        end
    end

    assign read_value = r_meta.rd_used ? rdata : EMPTY_WORD;
    assign o_m_tvalid = r_valid;
    assign o_m_tdata  = {7'b0, r_meta.empty, count8(r_meta.count), read_value};
    assign o_m_tuser  = r_meta.status;

endmodule

`default_nettype wire

[src/dqu_ram.sv]
// Generic single-port synchronous RAM with registered read data.
// No dependencies; read data holds until the next read.
`default_nettype none

module dqu_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic              i_re,
    input  wire logic [ADDR_W-1:0] i_addr,
    input  wire logic [WIDTH-1:0]  i_wdata,
    output logic      [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write on request
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
    end

    // Register read data, hold otherwise
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

[src/dqu_ctrl.sv]
// Head, tail and count registers of the queue; decodes each request into
// at most one store access and the result fields. Depends on dqu_pkg.
`default_nettype none

module dqu_ctrl (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_accept,
    input  wire logic [2:0]          i_op,
    input  wire logic [31:0]         i_push_value,
    output dqu_pkg::t_mem_req        o_mem_req,
    output dqu_pkg::t_res_meta       o_meta
);

    import dqu_pkg::*;

    logic [IDX_W-1:0] r_head, n_head;
    logic [IDX_W-1:0] r_tail, n_tail;
    logic [CNT_W-1:0] r_count, n_count;
    logic             full;
    logic             empty;
    t_status          status;
    logic             rd_used;

    assign full  = (r_count == CNT_W'(DEPTH));
    assign empty = (r_count == '0);

    // Decode the request into pointer updates and at most one store access
    always_comb begin
        n_head          = r_head;
        n_tail          = r_tail;
        n_count         = r_count;
        status          = ST_OK;
        rd_used         = 1'b0;
        o_mem_req.we    = 1'b0;
        o_mem_req.re    = 1'b0;
        o_mem_req.addr  = r_head;
        o_mem_req.wdata = i_push_value;
        case (t_op'(i_op))
            OP_PUSH_FRONT: begin
                if (full) begin
                    status = ST_OVERFLOW;
                end else begin
                    n_head         = idx_dec(r_head);
                    o_mem_req.we   = 1'b1;
                    o_mem_req.addr = idx_dec(r_head);
                    n_count        = r_count + CNT_W'(1);
                end
            end
            OP_PUSH_BACK: begin
                if (full) begin
                    status = ST_OVERFLOW;
                end else begin
                    n_tail         = idx_inc(r_tail);
                    o_mem_req.we   = 1'b1;
                    o_mem_req.addr = r_tail;
                    n_count        = r_count + CNT_W'(1);
                end
            end
            OP_POP_FRONT: begin
                if (empty) begin
                    status = ST_EMPTY;
                end else begin
                    n_head         = idx_inc(r_head);
                    o_mem_req.re   = 1'b1;
                    o_mem_req.addr = r_head;
                    rd_used        = 1'b1;
                    n_count        = r_count - CNT_W'(1);
                end
            end
            OP_POP_BACK: begin
                if (empty) begin
                    status = ST_EMPTY;
                end else begin
                    n_tail         = idx_dec(r_tail);
                    o_mem_req.re   = 1'b1;
                    o_mem_req.addr = idx_dec(r_tail);
                    rd_used        = 1'b1;
                    n_count        = r_count - CNT_W'(1);
                end
            end
            OP_PEEK_FRONT: begin
                if (empty) begin
                    status = ST_EMPTY;
                end else begin
                    o_mem_req.re   = 1'b1;
                    o_mem_req.addr = r_head;
                    rd_used        = 1'b1;
                end
            end
            OP_PEEK_BACK: begin
                if (empty) begin
                    status = ST_EMPTY;
                end else begin
                    o_mem_req.re   = 1'b1;
                    o_mem_req.addr = idx_dec(r_tail);
                    rd_used        = 1'b1;
                end
            end
            default: begin
                // Unused code: no access, count unchanged
                status = ST_OK;
            end
        endcase
        // Gate the store access with the handshake
        o_mem_req.we = o_mem_req.we & i_accept;
        o_mem_req.re = o_mem_req.re & i_accept;
    end

    assign o_meta.rd_used = rd_used;
    assign o_meta.status  = status;
    assign o_meta.count   = n_count;
    assign o_meta.empty   = (n_count == '0);

    // Advance pointers and count on each accepted request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else if (i_accept) begin
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
        end
    end

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("entry count exceeds store depth");

    a_empty_ptrs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0) |-> (r_head == r_tail))
        else $error("head and tail differ on empty store");

    a_full_ptrs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == CNT_W'(DEPTH)) |-> (r_head == r_tail))
        else $error("head and tail differ on full store");

    a_one_access: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_mem_req.we && o_mem_req.re))
        else $error("read and write issued together");

    a_idle_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_accept |=> $stable(r_count) && $stable(r_head) && $stable(r_tail))
        else $error("queue state moved without a request");
`endif

endmodule

`default_nettype wire
